FILE: hw/rtl/sfr_pkg.sv
// ============================================================================
// sfr_pkg
// Shared types and codes for the serial frame receiver.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

  // Input item kinds, carried on in_tuser
  localparam logic CMD_BYTE     = 1'b0;
  localparam logic CMD_LINE_ERR = 1'b1;

  // Configuration register indexes (byte address is 4 * index)
  localparam logic [1:0] REG_HEADER_FIRST  = 2'd0;
  localparam logic [1:0] REG_HEADER_SECOND = 2'd1;
  localparam logic [1:0] REG_MAX_LENGTH    = 2'd2;

  // Reset values of the configuration registers
  localparam logic [7:0] HEADER_FIRST_RST  = 8'd170;
  localparam logic [7:0] HEADER_SECOND_RST = 8'd85;
  localparam logic [5:0] MAX_LENGTH_RST    = 6'd32;

  // Output tdata width: id 8, command 8, length 6, byte 8, index 5, padded to bytes
  localparam int OUT_DATA_W = 40;

  typedef struct packed {
    logic [7:0] header_first;
    logic [7:0] header_second;
    logic [5:0] max_length;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic id_ld;      // take id byte, start checksum
    logic cmd_ld;     // take command byte
    logic len_ld;     // take length byte, clear payload index
    logic data_wr;    // store payload byte
    logic emit_clr;   // emit index back to zero
    logic emit_rd;    // read payload store at emit index
    logic out_load;   // load the output register
    logic emit_inc;   // advance emit index
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic line_err;
    logic hdr1_hit;
    logic hdr2_hit;
    logic len_ok;
    logic len_zero;
    logic data_done;
    logic csum_ok;
    logic emit_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sfr_cfg_regs.sv
// ============================================================================
// sfr_cfg_regs
// APB-style register block holding the header bytes and the length limit.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module sfr_cfg_regs (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output sfr_pkg::cfg_t          cfg
);

  sfr_pkg::cfg_t cfg_r;
  sfr_pkg::cfg_t cfg_nxt;
  logic          wr_en;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  // Register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        sfr_pkg::REG_HEADER_FIRST:  cfg_nxt.header_first  = pwdata[7:0];
        sfr_pkg::REG_HEADER_SECOND: cfg_nxt.header_second = pwdata[7:0];
        sfr_pkg::REG_MAX_LENGTH:    cfg_nxt.max_length    = pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_first  <= sfr_pkg::HEADER_FIRST_RST;
      cfg_r.header_second <= sfr_pkg::HEADER_SECOND_RST;
      cfg_r.max_length    <= sfr_pkg::MAX_LENGTH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      sfr_pkg::REG_HEADER_FIRST:  prdata = {24'd0, cfg_r.header_first};
      sfr_pkg::REG_HEADER_SECOND: prdata = {24'd0, cfg_r.header_second};
      sfr_pkg::REG_MAX_LENGTH:    prdata = {26'd0, cfg_r.max_length};
      default:                    prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sfr_ctrl.sv
// ============================================================================
// sfr_ctrl
// Frame parse and emit state machine.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module sfr_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire sfr_pkg::dp_status_t st,
  output sfr_pkg::ctrl_cmd_t       cmd
);

  localparam logic [3:0] S_HDR1    = 4'd0;
  localparam logic [3:0] S_HDR2    = 4'd1;
  localparam logic [3:0] S_ID      = 4'd2;
  localparam logic [3:0] S_CMD     = 4'd3;
  localparam logic [3:0] S_LEN     = 4'd4;
  localparam logic [3:0] S_DATA    = 4'd5;
  localparam logic [3:0] S_CSUM    = 4'd6;
  localparam logic [3:0] S_EMIT_RD = 4'd7;
  localparam logic [3:0] S_EMIT_LD = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       accept;
  logic       take_byte;

  // Bytes are taken in every parse state; the emit run stalls the input
  assign in_ready  = (state_r != S_EMIT_RD) && (state_r != S_EMIT_LD);
  assign accept    = in_valid & in_ready;
  assign take_byte = accept & ~st.line_err;

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    if (accept && st.line_err) begin
      state_nxt = S_HDR1;
    end else begin
      case (state_r)
        S_HDR1: begin
          if (take_byte && st.hdr1_hit) state_nxt = S_HDR2;
        end
        S_HDR2: begin
          if (take_byte) begin
            // second header wins over a repeated first header
            if (st.hdr2_hit)       state_nxt = S_ID;
            else if (!st.hdr1_hit) state_nxt = S_HDR1;
          end
        end
        S_ID: begin
          if (take_byte) begin
            cmd.id_ld = 1'b1;
            state_nxt = S_CMD;
          end
        end
        S_CMD: begin
          if (take_byte) begin
            cmd.cmd_ld = 1'b1;
            state_nxt  = S_LEN;
          end
        end
        S_LEN: begin
          if (take_byte) begin
            if (st.len_ok) begin
              cmd.len_ld = 1'b1;
              state_nxt  = st.len_zero ? S_CSUM : S_DATA;
            end else begin
              state_nxt = S_HDR1;
            end
          end
        end
        S_DATA: begin
          if (take_byte) begin
            cmd.data_wr = 1'b1;
            if (st.data_done) state_nxt = S_CSUM;
          end
        end
        S_CSUM: begin
          if (take_byte) begin
            if (st.csum_ok) begin
              cmd.emit_clr = 1'b1;
              state_nxt    = S_EMIT_RD;
            end else begin
              state_nxt = S_HDR1;
            end
          end
        end
        S_EMIT_RD: begin
          cmd.emit_rd = 1'b1;
          state_nxt   = S_EMIT_LD;
        end
        S_EMIT_LD: begin
          // wait until the output register can take the result
          if (st.out_free) begin
            cmd.out_load = 1'b1;
            if (st.emit_last) begin
              state_nxt = S_HDR1;
            end else begin
              cmd.emit_inc = 1'b1;
              state_nxt    = S_EMIT_RD;
            end
          end
        end
        default: begin
          state_nxt = S_HDR1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_HDR1;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sfr_datapath.sv
// ============================================================================
// sfr_datapath
// Held header fields, checksum, payload store and output register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module sfr_datapath #(
  parameter int MAX_PAYLOAD = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire sfr_pkg::cfg_t               cfg,
  input  wire logic                        in_cmd,
  input  wire logic [7:0]                  in_byte,
  input  wire sfr_pkg::ctrl_cmd_t          cmd,
  output sfr_pkg::dp_status_t              st,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [7:0]                       out_frame_id,
  output logic [7:0]                       out_command_code,
  output logic [5:0]                       out_payload_length,
  output logic                             out_has_payload,
  output logic [7:0]                       out_payload_byte,
  output logic [4:0]                       out_byte_index,
  output logic                             out_last
);

  localparam int         IDX_W    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [8:0] MAX_P9   = 9'(MAX_PAYLOAD);

  // Held frame fields and checksum
  logic [7:0] held_id_r;
  logic [7:0] held_cmd_r;
  logic [5:0] held_len_r;
  logic [5:0] pay_idx_r;
  logic [7:0] sum_r;
  logic [5:0] emit_k_r;

  // Payload store, written while parsing, read during the emit run
  logic [7:0] store_r [MAX_PAYLOAD];
  logic [7:0] rd_data_r;

  // Output register
  logic       out_valid_r;
  logic [7:0] out_id_r;
  logic [7:0] out_cc_r;
  logic [5:0] out_len_r;
  logic       out_has_r;
  logic [7:0] out_byte_r;
  logic [4:0] out_idx_r;
  logic       out_last_r;

  logic [6:0] pay_idx_inc;
  logic [6:0] emit_k_inc;
  logic       has_pay;

  assign pay_idx_inc = {1'b0, pay_idx_r} + 7'd1;
  assign emit_k_inc  = {1'b0, emit_k_r} + 7'd1;
  assign has_pay     = (held_len_r != 6'd0);

  // Status toward the controller
  always_comb begin
    st.line_err  = (in_cmd == sfr_pkg::CMD_LINE_ERR);
    st.hdr1_hit  = (in_byte == cfg.header_first);
    st.hdr2_hit  = (in_byte == cfg.header_second);
    st.len_ok    = (in_byte <= {2'b00, cfg.max_length}) && ({1'b0, in_byte} <= MAX_P9);
    st.len_zero  = (in_byte == 8'd0);
    st.data_done = (pay_idx_inc >= {1'b0, held_len_r});
    st.csum_ok   = (in_byte == sum_r);
    st.emit_last = !has_pay || (emit_k_inc == {1'b0, held_len_r});
    st.out_free  = !out_valid_r || out_ready;
  end

  // Header fields and running sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_id_r  <= 8'd0;
      held_cmd_r <= 8'd0;
      held_len_r <= 6'd0;
      pay_idx_r  <= 6'd0;
      sum_r      <= 8'd0;
    end else begin
      if (cmd.id_ld) begin
        held_id_r <= in_byte;
        sum_r     <= in_byte;
      end
      if (cmd.cmd_ld) begin
        held_cmd_r <= in_byte;
        sum_r      <= sum_r + in_byte;
      end
      if (cmd.len_ld) begin
        held_len_r <= in_byte[5:0];
        pay_idx_r  <= 6'd0;
        sum_r      <= sum_r + in_byte;
      end
      if (cmd.data_wr) begin
        pay_idx_r <= pay_idx_inc[5:0];
        sum_r     <= sum_r + in_byte;
      end
    end
  end

  // Payload store write and registered read
  always_ff @(posedge clk) begin
    if (cmd.data_wr) begin
      store_r[pay_idx_r[IDX_W-1:0]] <= in_byte;
    end
    if (cmd.emit_rd) begin
      rd_data_r <= store_r[emit_k_r[IDX_W-1:0]];
    end
  end

  // Emit index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_k_r <= 6'd0;
    end else if (cmd.emit_clr) begin
      emit_k_r <= 6'd0;
    end else if (cmd.emit_inc) begin
      emit_k_r <= emit_k_inc[5:0];
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_id_r   <= held_id_r;
      out_cc_r   <= held_cmd_r;
      out_len_r  <= held_len_r;
      out_has_r  <= has_pay;
      out_byte_r <= has_pay ? rd_data_r : 8'd0;
      out_idx_r  <= has_pay ? emit_k_r[4:0] : 5'd0;
      out_last_r <= st.emit_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_frame_id       = out_id_r;
  assign out_command_code   = out_cc_r;
  assign out_payload_length = out_len_r;
  assign out_has_payload    = out_has_r;
  assign out_payload_byte   = out_byte_r;
  assign out_byte_index     = out_idx_r;
  assign out_last           = out_last_r;

endmodule

`default_nettype wire

FILE: hw/rtl/serial_frame_receiver.sv
// ============================================================================
// serial_frame_receiver
// Header/length/checksum frame parser for a received UART byte stream.
// ============================================================================
// Bytes come in one item each (in_tuser = 1 marks a line error, which sends the
// parser back to header hunting). Every parse state takes one item per cycle.
// After a checksum byte that matches, the frame is sent out as a run of
// results, one per payload byte (a single result for an empty payload), and
// the input stalls during the run: each result takes a registered payload
// store read and then a load of the output register, and a result also waits
// while the output register is still full and not freed by out_tready. The
// last result may still wait in the output register while the next bytes are
// accepted. No clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module serial_frame_receiver #(
  parameter int MAX_PAYLOAD = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input channel
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [7:0]                        in_tdata,   // [7:0] rx_data
  input  wire logic                              in_tuser,   // [0] cmd
  // result channel
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [7:0] frame_id, [15:8] command_code, [21:16] payload_length,
  // [29:22] payload_byte, [34:30] byte_index, [39:35] zero
  output logic [sfr_pkg::OUT_DATA_W-1:0]         out_tdata,
  output logic                                   out_tuser,  // [0] has_payload
  output logic                                   out_tlast,
  // configuration port
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [3:0]                        cfg_paddr,
  input  wire logic [31:0]                       cfg_pwdata,
  output logic      [31:0]                       cfg_prdata,
  output logic                                   cfg_pready
);

  sfr_pkg::cfg_t       cfg;
  sfr_pkg::ctrl_cmd_t  cmd;
  sfr_pkg::dp_status_t st;

  logic [7:0] frame_id;
  logic [7:0] command_code;
  logic [5:0] payload_length;
  logic [7:0] payload_byte;
  logic [4:0] byte_index;

  sfr_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  sfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .st       (st),
    .cmd      (cmd)
  );

  sfr_datapath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .in_cmd             (in_tuser),
    .in_byte            (in_tdata),
    .cmd                (cmd),
    .st                 (st),
    .out_valid          (out_tvalid),
    .out_ready          (out_tready),
    .out_frame_id       (frame_id),
    .out_command_code   (command_code),
    .out_payload_length (payload_length),
    .out_has_payload    (out_tuser),
    .out_payload_byte   (payload_byte),
    .out_byte_index     (byte_index),
    .out_last           (out_tlast)
  );

  // Pack result fields, lowest field first
  assign out_tdata = {5'd0, byte_index, payload_byte, payload_length,
                      command_code, frame_id};

endmodule

`default_nettype wire

FILE: test/sfr_frame_monitor.sv
// ============================================================================
// sfr_frame_monitor
// Watches the byte, result and register ports of the serial frame receiver,
// tracks the parse of every accepted byte and checks each result item field by
// field against the frame it should belong to.
// ============================================================================
`timescale 1ns / 1ps

module sfr_frame_monitor (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [7:0]                     in_tdata,    // [7:0] rx_data
  input  logic                           in_tuser,    // [0] cmd
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  // [7:0] frame_id, [15:8] command_code, [21:16] payload_length,
  // [29:22] payload_byte, [34:30] byte_index, [39:35] zero
  input  logic [sfr_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           out_tuser,   // [0] has_payload
  input  logic                           out_tlast,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic                           cfg_pready,
  input  logic [3:0]                     cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output int                             mismatch_count,
  output int                             results_due
);

  localparam int STORE_DEPTH = 32;

  typedef enum logic [2:0] {
    PS_HUNT, PS_HDR2, PS_ID, PS_CMD, PS_LEN, PS_DATA, PS_CSUM
  } scan_t;

  typedef struct packed {
    logic [7:0] frame_id;
    logic [7:0] command_code;
    logic [5:0] payload_length;
    logic       has_payload;
    logic [7:0] payload_byte;
    logic [4:0] byte_index;
    logic       is_last;
  } beat_t;

  // register copies
  logic [7:0] hdr_a;
  logic [7:0] hdr_b;
  logic [5:0] len_cap;

  // parser copy
  scan_t      scan;
  logic [7:0] frame_id_q;
  logic [7:0] frame_cmd_q;
  logic [5:0] frame_len_q;
  logic [5:0] fill_idx;
  logic [7:0] sum_acc;
  logic [7:0] payload_mem [STORE_DEPTH];

  beat_t beats_due [$];
  beat_t seen_beat;
  beat_t due_beat;
  int    miss_total = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    miss_total++;
    $display("%0t ns  mismatch on %s: got %0d, want %0d", $time, what, got, want);
  endtask

  // Advance the parse by one accepted item; queue the frame's results on a
  // matching checksum
  task automatic parse_rx(input logic kind, input logic [7:0] b);
    beat_t beat;
    int    k;
    if (kind == sfr_pkg::CMD_LINE_ERR) begin
      scan = PS_HUNT;
      return;
    end
    case (scan)
      PS_HUNT: if (b == hdr_a) scan = PS_HDR2;
      PS_HDR2: begin
        // second header wins when both are equal
        if (b == hdr_b)      scan = PS_ID;
        else if (b != hdr_a) scan = PS_HUNT;
      end
      PS_ID: begin
        frame_id_q = b;
        sum_acc    = b;
        scan       = PS_CMD;
      end
      PS_CMD: begin
        frame_cmd_q = b;
        sum_acc     = sum_acc + b;
        scan        = PS_LEN;
      end
      PS_LEN: begin
        if (b <= {2'b00, len_cap} && b <= STORE_DEPTH) begin
          frame_len_q = b[5:0];
          fill_idx    = '0;
          sum_acc     = sum_acc + b;
          scan        = (b == 8'd0) ? PS_CSUM : PS_DATA;
        end else begin
          scan = PS_HUNT;
        end
      end
      PS_DATA: begin
        if (fill_idx < STORE_DEPTH) payload_mem[fill_idx[4:0]] = b;
        fill_idx = fill_idx + 6'd1;
        sum_acc  = sum_acc + b;
        if (fill_idx >= frame_len_q) scan = PS_CSUM;
      end
      PS_CSUM: begin
        if (b == sum_acc) begin
          beat.frame_id     = frame_id_q;
          beat.command_code = frame_cmd_q;
          if (frame_len_q == 6'd0) begin
            beat.payload_length = '0;
            beat.has_payload    = 1'b0;
            beat.payload_byte   = '0;
            beat.byte_index     = '0;
            beat.is_last        = 1'b1;
            beats_due.push_back(beat);
          end else begin
            for (k = 0; k < frame_len_q; k++) begin
              beat.payload_length = frame_len_q;
              beat.has_payload    = 1'b1;
              beat.payload_byte   = payload_mem[k[4:0]];
              beat.byte_index     = k[4:0];
              beat.is_last        = (k + 1 == frame_len_q);
              beats_due.push_back(beat);
            end
          end
        end
        scan = PS_HUNT;
      end
      default: scan = PS_HUNT;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      hdr_a       = sfr_pkg::HEADER_FIRST_RST;
      hdr_b       = sfr_pkg::HEADER_SECOND_RST;
      len_cap     = sfr_pkg::MAX_LENGTH_RST;
      scan        = PS_HUNT;
      frame_id_q  = '0;
      frame_cmd_q = '0;
      frame_len_q = '0;
      fill_idx    = '0;
      sum_acc     = '0;
      beats_due.delete();
    end else begin
      // result side first: a result taken at this edge is never one of the
      // results queued by the byte taken at the same edge
      if (out_tvalid && out_tready) begin
        seen_beat.frame_id       = out_tdata[7:0];
        seen_beat.command_code   = out_tdata[15:8];
        seen_beat.payload_length = out_tdata[21:16];
        seen_beat.payload_byte   = out_tdata[29:22];
        seen_beat.byte_index     = out_tdata[34:30];
        seen_beat.has_payload    = out_tuser;
        seen_beat.is_last        = out_tlast;
        if (beats_due.size() == 0) begin
          report_mismatch("result with none due (frame_id)", seen_beat.frame_id, -1);
        end else begin
          due_beat = beats_due.pop_front();
          if (seen_beat.frame_id != due_beat.frame_id)
            report_mismatch("frame_id", seen_beat.frame_id, due_beat.frame_id);
          if (seen_beat.command_code != due_beat.command_code)
            report_mismatch("command_code", seen_beat.command_code, due_beat.command_code);
          if (seen_beat.payload_length != due_beat.payload_length)
            report_mismatch("payload_length", seen_beat.payload_length,
                            due_beat.payload_length);
          if (seen_beat.has_payload != due_beat.has_payload)
            report_mismatch("has_payload", seen_beat.has_payload, due_beat.has_payload);
          if (seen_beat.payload_byte != due_beat.payload_byte)
            report_mismatch("payload_byte", seen_beat.payload_byte, due_beat.payload_byte);
          if (seen_beat.byte_index != due_beat.byte_index)
            report_mismatch("byte_index", seen_beat.byte_index, due_beat.byte_index);
          if (seen_beat.is_last != due_beat.is_last)
            report_mismatch("last", seen_beat.is_last, due_beat.is_last);
        end
      end

      if (in_tvalid && in_tready) parse_rx(in_tuser, in_tdata);

      // register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          sfr_pkg::REG_HEADER_FIRST:  hdr_a   = cfg_pwdata[7:0];
          sfr_pkg::REG_HEADER_SECOND: hdr_b   = cfg_pwdata[7:0];
          sfr_pkg::REG_MAX_LENGTH:    len_cap = cfg_pwdata[5:0];
          default: ;
        endcase
      end
    end
    mismatch_count <= miss_total;
    results_due    <= beats_due.size();
  end

endmodule

FILE: test/serial_frame_receiver_test.sv
// ============================================================================
// serial_frame_receiver_test
// Drives byte items, line errors and register writes into the serial frame
// receiver: a directed opening, then random frames over several header and
// length settings, with random idling on both channels, a long result stall
// and full drains between settings. The monitor does the checking.
// ============================================================================
`timescale 1ns / 1ps

module serial_frame_receiver_test;

  localparam int LONG_HOLD      = 400;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 4000;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [7:0]                     in_tdata;   // [7:0] rx_data
  logic                           in_tuser;   // [0] cmd
  logic                           out_tvalid;
  logic                           out_tready;
  // [7:0] frame_id, [15:8] command_code, [21:16] payload_length,
  // [29:22] payload_byte, [34:30] byte_index, [39:35] zero
  logic [sfr_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           out_tuser;  // [0] has_payload
  logic                           out_tlast;
  logic                           cfg_psel;
  logic                           cfg_penable;
  logic                           cfg_pwrite;
  logic [3:0]                     cfg_paddr;
  logic [31:0]                    cfg_pwdata;
  logic [31:0]                    cfg_prdata;
  logic                           cfg_pready;

  int mismatch_count;
  int results_due;

  // stimulus control
  int         items_sent = 0;
  int         idle_cycles = 0;
  bit         in_steady = 1'b0;
  bit         out_steady = 1'b0;
  bit         hold_req = 1'b0;
  logic [7:0] hdr_one = sfr_pkg::HEADER_FIRST_RST;
  logic [7:0] hdr_two = sfr_pkg::HEADER_SECOND_RST;
  int         len_cap = int'(sfr_pkg::MAX_LENGTH_RST);

  always #5 clk = ~clk;

  serial_frame_receiver u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  sfr_frame_monitor u_monitor (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_pready     (cfg_pready),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  // mostly short gaps, a few long ones
  function automatic int pause_len();
    int r;
    r = $urandom_range(99);
    if (r < 70)      return $urandom_range(1, 3);
    else if (r < 95) return $urandom_range(4, 12);
    else             return $urandom_range(20, 80);
  endfunction

  // One item on the byte channel; valid stays high across back-to-back items
  task automatic send_item(input logic kind, input logic [7:0] val);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= val;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (!in_steady && $urandom_range(99) < 30) begin
      in_tvalid <= 1'b0;
      repeat (pause_len()) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {24'd0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Stop sending until every due result is out and the block has gone quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] h1, input logic [7:0] h2, input int cap);
    settle();
    hdr_one = h1;
    hdr_two = h2;
    len_cap = cap;
    write_reg(sfr_pkg::REG_HEADER_FIRST, h1);
    write_reg(sfr_pkg::REG_HEADER_SECOND, h2);
    write_reg(sfr_pkg::REG_MAX_LENGTH, cap[7:0]);
  endtask

  // Build a frame; a length above the store size stops after the length byte.
  // cut_at < 0 means no line error, else the byte at that position is replaced
  // by one and the rest of the frame is dropped.
  task automatic send_frame(input int len, input bit bad_sum, input int cut_at,
                            input bit dup_head);
    logic [7:0] seq [$];
    logic [7:0] id_b;
    logic [7:0] op_b;
    logic [7:0] sum_b;
    logic [7:0] pl;
    int         i;
    id_b = 8'($urandom);
    op_b = 8'($urandom);
    sum_b = id_b + op_b + len[7:0];
    if (dup_head) repeat ($urandom_range(1, 3)) seq.push_back(hdr_one);
    seq.push_back(hdr_one);
    seq.push_back(hdr_two);
    seq.push_back(id_b);
    seq.push_back(op_b);
    seq.push_back(len[7:0]);
    if (len <= 32) begin
      for (i = 0; i < len; i++) begin
        pl = 8'($urandom);
        sum_b = sum_b + pl;
        seq.push_back(pl);
      end
      seq.push_back(bad_sum ? sum_b ^ 8'($urandom_range(1, 255)) : sum_b);
    end
    for (i = 0; i < seq.size(); i++) begin
      if (i == cut_at) begin
        send_item(sfr_pkg::CMD_LINE_ERR, 8'($urandom));
        return;
      end
      send_item(sfr_pkg::CMD_BYTE, seq[i]);
    end
  endtask

  // Mostly well-formed frames with random content; some noise and broken ones
  task automatic send_random_traffic();
    int r;
    int len;
    int cut;
    r = $urandom_range(99);
    if (r < 12) begin
      repeat ($urandom_range(1, 4))
        send_item(($urandom_range(99) < 35) ? sfr_pkg::CMD_LINE_ERR : sfr_pkg::CMD_BYTE,
                  8'($urandom));
    end else begin
      r = $urandom_range(99);
      if (r < 10)      len = len_cap;
      else if (r < 20) len = $urandom_range(255);
      else             len = $urandom_range(0, (len_cap < 6) ? len_cap : 6);
      cut = ($urandom_range(99) < 10) ? $urandom_range(0, len + 5) : -1;
      send_frame(len, $urandom_range(99) < 10, cut, $urandom_range(99) < 15);
    end
  endtask

  task automatic run_random(input int upto);
    while (items_sent < upto) send_random_traffic();
  endtask

  // result side: random stalls, and the long hold-off on request
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_tready <= 1'b1;
      end else if (!out_steady && $urandom_range(99) < 15) begin
        out_tready <= 1'b0;
        repeat (pause_len()) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no item taken on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= sfr_pkg::CMD_BYTE;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset headers
    // repeated first header, extreme id and command, empty payload
    send_item(sfr_pkg::CMD_BYTE, sfr_pkg::HEADER_FIRST_RST);
    send_item(sfr_pkg::CMD_BYTE, sfr_pkg::HEADER_FIRST_RST);
    send_item(sfr_pkg::CMD_BYTE, sfr_pkg::HEADER_SECOND_RST);
    send_item(sfr_pkg::CMD_BYTE, 8'hFF);
    send_item(sfr_pkg::CMD_BYTE, 8'h00);
    send_item(sfr_pkg::CMD_BYTE, 8'h00);
    send_item(sfr_pkg::CMD_BYTE, 8'hFF);
    // stray byte, then a length above the store size
    send_item(sfr_pkg::CMD_BYTE, 8'h13);
    send_item(sfr_pkg::CMD_BYTE, sfr_pkg::HEADER_FIRST_RST);
    send_item(sfr_pkg::CMD_BYTE, sfr_pkg::HEADER_SECOND_RST);
    send_item(sfr_pkg::CMD_BYTE, 8'h01);
    send_item(sfr_pkg::CMD_BYTE, 8'h02);
    send_item(sfr_pkg::CMD_BYTE, 8'd33);
    // line error inside the payload
    send_item(sfr_pkg::CMD_BYTE, sfr_pkg::HEADER_FIRST_RST);
    send_item(sfr_pkg::CMD_BYTE, sfr_pkg::HEADER_SECOND_RST);
    send_item(sfr_pkg::CMD_BYTE, 8'h10);
    send_item(sfr_pkg::CMD_BYTE, 8'h20);
    send_item(sfr_pkg::CMD_BYTE, 8'h01);
    send_item(sfr_pkg::CMD_LINE_ERR, 8'h5C);
    // checksum mismatch (good sum is 0xB1)
    send_item(sfr_pkg::CMD_BYTE, sfr_pkg::HEADER_FIRST_RST);
    send_item(sfr_pkg::CMD_BYTE, sfr_pkg::HEADER_SECOND_RST);
    send_item(sfr_pkg::CMD_BYTE, 8'h10);
    send_item(sfr_pkg::CMD_BYTE, 8'h20);
    send_item(sfr_pkg::CMD_BYTE, 8'h01);
    send_item(sfr_pkg::CMD_BYTE, 8'h80);
    send_item(sfr_pkg::CMD_BYTE, 8'h4E);

    // extreme headers, full length; long result stall fills the block
    set_config(8'h00, 8'hFF, 32);
    hold_req = 1'b1;
    repeat (2) send_frame($urandom_range(20, 32), 1'b0, -1, 1'b0);
    run_random(110);

    // reversed extremes, empty payloads only, no idling anywhere
    set_config(8'hFF, 8'h00, 0);
    in_steady  = 1'b1;
    out_steady = 1'b1;
    run_random(135);
    in_steady  = 1'b0;
    out_steady = 1'b0;

    // equal headers: the second-header match wins
    set_config(8'h5A, 8'h5A, 7);
    run_random(160);

    // random setting
    set_config(8'($urandom), 8'($urandom), $urandom_range(0, 32));
    run_random(180);

    settle();
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_cfg_regs.sv
hw/rtl/sfr_ctrl.sv
hw/rtl/sfr_datapath.sv
hw/rtl/serial_frame_receiver.sv
test/sfr_frame_monitor.sv
test/serial_frame_receiver_test.sv
